// ===== rtl/core/line_address_set_table_assert.svh =====
// Assertion macros shared by the line address set table RTL
`ifndef LINE_ADDRESS_SET_TABLE_ASSERT_SVH
`define LINE_ADDRESS_SET_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LAST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line address set table: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define LAST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("line address set table: next-cycle check failed");

`endif

// ===== rtl/core/last_pkg.sv =====
// Shared types, codes and widths for the line address set table
package last_pkg;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 64;
    localparam int POS_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;
    localparam int SHIFT_W    = 5;

    // Defaults
    localparam int          CAPACITY_DEF     = 64;
    localparam logic [SHIFT_W-1:0] LINE_SHIFT_RESET = 5'd6;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_AT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    // Read address selects
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_LAST = 2'd1;
    localparam logic [1:0] RD_POS  = 2'd2;
    localparam logic [1:0] RD_NEXT = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic       start;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       take_value;
        logic       move;
        logic       step;
        logic       set_found;
        logic       dec_count;
        logic       load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic              in_err;
        logic              empty;
        logic              last;
        logic              hit;
    } dp_stat_t;

endpackage

// ===== rtl/core/last_ram.sv =====
// Generic simple dual-port RAM with registered read
module last_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/last_dp.sv =====
// Datapath: entry store, count, line shift register, scan and compaction
module last_dp #(
    parameter int CAPACITY = last_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [last_pkg::SHIFT_W-1:0]    cfg_wr_data,
    input  logic [last_pkg::FUNC_W-1:0]     s_func,
    input  logic [last_pkg::ADDR_W-1:0]     s_addr,
    input  logic [last_pkg::POS_W-1:0]      s_position,
    input  last_pkg::ctrl_cmd_t             cmd,
    output last_pkg::dp_stat_t              stat,
    output logic [last_pkg::ADDR_W-1:0]     m_value,
    output logic                            m_found,
    output logic [last_pkg::STATUS_W-1:0]   m_status,
    output logic [last_pkg::OCC_W-1:0]      m_occupancy
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > last_pkg::POS_W) ? CNT_W : last_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]                count_reg, count_next;
    logic [last_pkg::SHIFT_W-1:0]    shift_reg;
    logic [AW-1:0]                   idx_reg;
    logic [last_pkg::ADDR_W-1:0]     query_reg;
    logic [last_pkg::ADDR_W-1:0]     res_value_reg;
    logic                            res_found_reg;
    logic [last_pkg::STATUS_W-1:0]   res_status_reg;
    logic [last_pkg::ADDR_W-1:0]     m_value_reg;
    logic                            m_found_reg;
    logic [last_pkg::STATUS_W-1:0]   m_status_reg;
    logic [last_pkg::OCC_W-1:0]      m_occupancy_reg;

    logic [last_pkg::STATUS_W-1:0]   in_status;
    logic                            push_ok;
    logic [CMP_W-1:0]                pos_cmp, count_cmp;
    logic [AW+last_pkg::POS_W-1:0]   pos_ext;
    logic [AW-1:0]                   pos_idx;
    logic [CNT_W-1:0]                count_m1, idx_p1;
    logic [CNT_W+last_pkg::OCC_W-1:0] count_ext;
    logic                            wr_en, rd_en;
    logic [AW-1:0]                   wr_addr, rd_addr;
    logic [last_pkg::ADDR_W-1:0]     wr_data, rd_data;

    // Classify the incoming word against the current count
    assign pos_cmp   = CMP_W'(s_position);
    assign count_cmp = CMP_W'(count_reg);
    assign pos_ext   = (AW + last_pkg::POS_W)'(s_position);
    assign pos_idx   = pos_ext[AW-1:0];

    always_comb begin
        case (s_func)
            last_pkg::FUNC_PUSH:
                in_status = (count_reg >= CAP_CNT) ? last_pkg::ST_FULL : last_pkg::ST_OK;
            last_pkg::FUNC_POP:
                in_status = (count_reg == '0) ? last_pkg::ST_EMPTY : last_pkg::ST_OK;
            last_pkg::FUNC_POP_AT:
                in_status = (pos_cmp >= count_cmp) ? last_pkg::ST_BADIDX : last_pkg::ST_OK;
            default:
                in_status = last_pkg::ST_OK;
        endcase
    end

    assign push_ok  = cmd.start && (s_func == last_pkg::FUNC_PUSH) && (in_status == last_pkg::ST_OK);
    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_p1   = CNT_W'(idx_reg) + CNT_W'(1);

    // Status back to the controller
    assign stat.in_func = s_func;
    assign stat.in_err  = (in_status != last_pkg::ST_OK);
    assign stat.empty   = (count_reg == '0);
    assign stat.last    = (idx_p1 >= count_reg);
    assign stat.hit     = ((rd_data >> shift_reg) == query_reg);

    // Entry store ports
    assign wr_en   = push_ok || cmd.move;
    assign wr_addr = cmd.move ? (idx_reg - AW'(1)) : count_reg[AW-1:0];
    assign wr_data = cmd.move ? rd_data : s_addr;
    assign rd_en   = cmd.rd_en;

    always_comb begin
        case (cmd.rd_sel)
            last_pkg::RD_ZERO: rd_addr = '0;
            last_pkg::RD_LAST: rd_addr = count_m1[AW-1:0];
            last_pkg::RD_POS:  rd_addr = pos_idx;
            last_pkg::RD_NEXT: rd_addr = idx_p1[AW-1:0];
            default:           rd_addr = '0;
        endcase
    end

    last_ram #(
        .WIDTH (last_pkg::ADDR_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Count update
    always_comb begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.dec_count) begin
            count_next = count_m1;
        end
    end

    // Control state: count and line shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            shift_reg <= last_pkg::LINE_SHIFT_RESET;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                shift_reg <= cfg_wr_data;
            end
        end
    end

    // Working registers for the current word
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            query_reg      <= s_addr >> shift_reg;
            idx_reg        <= (s_func == last_pkg::FUNC_POP_AT) ? pos_idx : '0;
            res_value_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= in_status;
        end else begin
            if (cmd.step) begin
                idx_reg <= idx_p1[AW-1:0];
            end
            if (cmd.take_value) begin
                res_value_reg <= rd_data;
            end
            if (cmd.set_found) begin
                res_found_reg <= 1'b1;
            end
        end
    end

    // Output register
    assign count_ext = (CNT_W + last_pkg::OCC_W)'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_value_reg     <= res_value_reg;
            m_found_reg     <= res_found_reg;
            m_status_reg    <= res_status_reg;
            m_occupancy_reg <= count_ext[last_pkg::OCC_W-1:0];
        end
    end

    assign m_value     = m_value_reg;
    assign m_found     = m_found_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occupancy_reg;

endmodule

// ===== rtl/core/last_ctrl.sv =====
// Controller: sequences push, pop, compaction and line scan
module last_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  last_pkg::dp_stat_t  stat,
    output last_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_POPI  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    if (stat.in_err) begin
                        state_next = S_FIN;
                    end else begin
                        case (stat.in_func)
                            last_pkg::FUNC_PUSH: begin
                                state_next = S_FIN;
                            end
                            last_pkg::FUNC_POP: begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = last_pkg::RD_LAST;
                                state_next = S_POP;
                            end
                            last_pkg::FUNC_POP_AT: begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = last_pkg::RD_POS;
                                state_next = S_POPI;
                            end
                            default: begin
                                if (stat.empty) begin
                                    state_next = S_FIN;
                                end else begin
                                    cmd.rd_en  = 1'b1;
                                    cmd.rd_sel = last_pkg::RD_ZERO;
                                    state_next = S_SCAN;
                                end
                            end
                        endcase
                    end
                end
            end
            S_POP: begin
                cmd.take_value = 1'b1;
                cmd.dec_count  = 1'b1;
                state_next     = S_FIN;
            end
            S_POPI: begin
                cmd.take_value = 1'b1;
                if (stat.last) begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = last_pkg::RD_NEXT;
                    cmd.step   = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // move the entry just read down one place
                cmd.move = 1'b1;
                if (stat.last) begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = last_pkg::RD_NEXT;
                    cmd.step   = 1'b1;
                end
            end
            S_SCAN: begin
                if (stat.hit) begin
                    cmd.set_found = 1'b1;
                    state_next    = S_FIN;
                end else if (stat.last) begin
                    state_next = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = last_pkg::RD_NEXT;
                    cmd.step   = 1'b1;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/core/line_address_set_table.sv =====
// Line address set table: top level joining controller and datapath
//
// Input channel s_*: one word per operation (s_func, s_addr, s_position),
// taken on s_valid & s_ready. Result channel m_*: one word per operation
// (m_value, m_found, m_status, m_occupancy), handed over on m_valid & m_ready.
// line_shift is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this. With the
// receiver ready, push and every error go straight to the output register;
// pop reads the last entry, then takes it and decrements the count; pop at
// index reads the entry at position, then moves each later entry down one
// place, one move per cycle, and decrements the count; lookup goes straight
// to the output register when empty, else reads entries from index 0 until
// the first hit (at most count), one entry per cycle. The entry RAM has a
// single read port, so entries are read one at a time. s_ready is high only
// between operations, so one word is at work at a time; it returns together
// with m_valid. The next word is taken while the result waits in the output
// register; if the receiver stalls, the following result is held until the
// output register frees.
// Synchronous reset clears the count, sets line_shift to 6 and drops m_valid.
module line_address_set_table #(
    parameter int CAPACITY = last_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [last_pkg::SHIFT_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [last_pkg::FUNC_W-1:0]   s_func,
    input  logic [last_pkg::ADDR_W-1:0]   s_addr,
    input  logic [last_pkg::POS_W-1:0]    s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [last_pkg::ADDR_W-1:0]   m_value,
    output logic                          m_found,
    output logic [last_pkg::STATUS_W-1:0] m_status,
    output logic [last_pkg::OCC_W-1:0]    m_occupancy
);

    last_pkg::ctrl_cmd_t cmd;
    last_pkg::dp_stat_t  stat;

    last_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    last_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_func      (s_func),
        .s_addr      (s_addr),
        .s_position  (s_position),
        .cmd         (cmd),
        .stat        (stat),
        .m_value     (m_value),
        .m_found     (m_found),
        .m_status    (m_status),
        .m_occupancy (m_occupancy)
    );

`include "line_address_set_table_assert.svh"

    // One word at a time: after acceptance the input side closes
    `LAST_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    // Loading the output register raises m_valid
    `LAST_ASSERT_NEXT(a_load_valid, cmd.load_out, m_valid)
    // An error result never carries a value or a hit
    `LAST_ASSERT_NOW(a_err_clean, m_valid && (m_status != last_pkg::ST_OK), (m_value == '0) && !m_found)
    // Compaction and scan never run while a word is being accepted
    `LAST_ASSERT_NOW(a_no_overlap, cmd.move || cmd.step, !cmd.start)

endmodule
